>>> src/cmp_pkg.sv
// ----------------------------------------------------------------------------
// CoAP message parser package
// Shared payload types, byte classes, status codes and the small helpers that
// decode an option's delta and length nibbles.
// ----------------------------------------------------------------------------
package cmp_pkg;

  // Classes of a parsed byte.
  localparam logic [2:0] CLS_HEADER  = 3'd0;
  localparam logic [2:0] CLS_TOKEN   = 3'd1;
  localparam logic [2:0] CLS_OPTHDR  = 3'd2;
  localparam logic [2:0] CLS_OPTVAL  = 3'd3;
  localparam logic [2:0] CLS_MARKER  = 3'd4;
  localparam logic [2:0] CLS_PAYLOAD = 3'd5;
  localparam logic [2:0] CLS_DISCARD = 3'd6;

  // Status codes, reported on the final byte of a message.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_TKL_LONG  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_RSVD_NIB  = 3'd5;
  localparam logic [2:0] ST_OPT_LIMIT = 3'd6;

  // Protocol constants.
  localparam logic [1:0]  PROTO_VER    = 2'd1;
  localparam logic [3:0]  MAX_TKL      = 4'd8;
  localparam logic [7:0]  PAYLOAD_MARK = 8'hFF;
  localparam logic [3:0]  NIB_EXT8     = 4'd13;
  localparam logic [3:0]  NIB_EXT16    = 4'd14;
  localparam logic [3:0]  NIB_RSVD     = 4'd15;
  localparam logic [15:0] EXT8_BASE    = 16'd13;
  localparam logic [15:0] EXT16_BASE   = 16'd269;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  data_out;
    logic [15:0] option_number;
    logic [15:0] option_length;
    logic        message_end;
    logic [2:0]  status;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [7:0]  code;
    logic [15:0] message_id;
    logic [4:0]  option_count;
    logic [15:0] payload_length;
  } out_item_t;

  // Number of extension bytes that follow for a delta or length nibble.
  function automatic logic [1:0] ext_bytes(input logic [3:0] nib);
    logic [1:0] n;
    n = 2'd0;
    if (nib == NIB_EXT8) n = 2'd1;
    else if (nib == NIB_EXT16) n = 2'd2;
    return n;
  endfunction

  // Value of a delta or length nibble once its extension bytes are in.
  function automatic logic [15:0] nibble_value(input logic [3:0] nib,
                                               input logic [15:0] accum);
    logic [15:0] v;
    v = {12'd0, nib};
    if (nib == NIB_EXT8) v = accum + EXT8_BASE;
    else if (nib == NIB_EXT16) v = accum + EXT16_BASE;
    return v;
  endfunction

endpackage

>>> src/cmp_stream_if.sv
// ----------------------------------------------------------------------------
// CoAP parser stream interface
// A valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface cmp_stream_if #(
  parameter type payload_t = logic [7:0]
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> src/coap_message_parser_top.sv
// ----------------------------------------------------------------------------
// CoAP message parser: the result of each accepted byte is registered in the
// output register, or in the skid stage while the output register still holds a result.
// Throughput is one byte per clock while the sink keeps taking results; the option
// header path (nibble add, then the running option number add) is the longest
// single-cycle path. Reset is asynchronous and active low; no clearing pass is needed after it.
module coap_message_parser_top
  import cmp_pkg::*;
#(
  parameter int unsigned MAX_OPTIONS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cmp_stream_if.sink   req_i,
  cmp_stream_if.source res_o
);

  // The option counter must hold MAX_OPTIONS itself, and is at least as wide
  // as the five-bit option_count field so that the field is a plain slice.
  localparam int unsigned CNT_RAW = $clog2(MAX_OPTIONS + 1);
  localparam int unsigned CNT_W   = (CNT_RAW > 5) ? CNT_RAW : 5;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TOKEN,
    PH_OPTHEAD,
    PH_EXT,
    PH_VALUE,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_e;

  // Complete parsing context of the message in flight.
  typedef struct packed {
    phase_e             phase;
    logic [1:0]         hdr_idx;
    logic [2:0]         err;
    logic [1:0]         msg_type;
    logic [3:0]         tkl;
    logic [7:0]         code;
    logic [15:0]        mid;
    logic [3:0]         tok_left;
    logic [3:0]         delta_nib;
    logic [3:0]         len_nib;
    logic [2:0]         ext_left;
    logic [15:0]        delta_acc;
    logic [15:0]        len_acc;
    logic [15:0]        run_num;
    logic [15:0]        cur_len;
    logic [15:0]        val_left;
    logic [CNT_W-1:0]   seen;
    logic [15:0]        pay_cnt;
  } st_t;

  localparam st_t ST_RESET = '{phase: PH_HEADER, default: '0};

  st_t       st_q, st_d;
  out_item_t res_d;
  out_item_t out_q, skid_q;
  logic      out_vld_q, skid_vld_q;
  logic      push, pop;
  logic [7:0] b;
  logic       last;

  assign b    = req_i.data.data_byte;
  assign last = req_i.data.last_byte;

  // The skid stage lets a new byte in while the output register still holds
  // a result the sink has not taken. Ready depends on registers only.
  assign req_i.ready = !skid_vld_q;
  assign push        = req_i.valid && req_i.ready;
  assign pop         = out_vld_q && res_o.ready;

  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  // --------------------------------------------------------------------------
  // Per-byte parsing. Everything is computed from the current context and the
  // incoming byte; the results reflect the context after this byte.
  // --------------------------------------------------------------------------
  always_comb begin
    logic             hdr_done;
    logic             opt_done;
    logic [15:0]      delta_v;
    logic [15:0]      len_v;
    logic [2:0]       ext_sum;
    logic [CNT_W-1:0] seen_inc;
    logic [2:0]       cls;
    logic [2:0]       status;

    st_d     = st_q;
    hdr_done = 1'b0;
    opt_done = 1'b0;
    cls      = CLS_DISCARD;
    status   = ST_OK;
    ext_sum  = {1'b0, ext_bytes(b[7:4])} + {1'b0, ext_bytes(b[3:0])};
    seen_inc = st_q.seen + 1'b1;

    unique case (st_q.phase)
      PH_HEADER: begin
        cls = CLS_HEADER;
        st_d.hdr_idx = st_q.hdr_idx + 2'd1;
        case (st_q.hdr_idx)
          2'd0: begin
            st_d.msg_type = b[5:4];
            st_d.tkl      = b[3:0];
            if (b[7:6] != PROTO_VER) st_d.err = ST_BAD_VER;
            else if (b[3:0] > MAX_TKL) st_d.err = ST_TKL_LONG;
          end
          2'd1: st_d.code = b;
          2'd2: st_d.mid[15:8] = b;
          default: begin
            st_d.mid[7:0] = b;
            st_d.tok_left = st_q.tkl;
            if (st_q.err != ST_OK) st_d.phase = PH_DISCARD;
            else if (st_q.tkl != 4'd0) st_d.phase = PH_TOKEN;
            else st_d.phase = PH_OPTHEAD;
          end
        endcase
      end
      PH_TOKEN: begin
        cls = CLS_TOKEN;
        st_d.tok_left = st_q.tok_left - 4'd1;
        if (st_q.tok_left == 4'd1) st_d.phase = PH_OPTHEAD;
      end
      PH_OPTHEAD: begin
        if (b == PAYLOAD_MARK) begin
          cls = CLS_MARKER;
          st_d.phase = PH_PAYLOAD;
        end else begin
          cls = CLS_OPTHDR;
          if (b[7:4] == NIB_RSVD || b[3:0] == NIB_RSVD) begin
            st_d.err   = ST_RSVD_NIB;
            st_d.phase = PH_DISCARD;
          end else begin
            st_d.delta_nib = b[7:4];
            st_d.len_nib   = b[3:0];
            st_d.delta_acc = '0;
            st_d.len_acc   = '0;
            st_d.ext_left  = ext_sum;
            if (ext_sum == 3'd0) hdr_done = 1'b1;
            else st_d.phase = PH_EXT;
          end
        end
      end
      PH_EXT: begin
        cls = CLS_OPTHDR;
        // Delta extension bytes come first, then the length ones.
        if (st_q.ext_left > {1'b0, ext_bytes(st_q.len_nib)}) begin
          st_d.delta_acc = {st_q.delta_acc[7:0], b};
        end else begin
          st_d.len_acc = {st_q.len_acc[7:0], b};
        end
        st_d.ext_left = st_q.ext_left - 3'd1;
        if (st_q.ext_left == 3'd1) hdr_done = 1'b1;
      end
      PH_VALUE: begin
        cls = CLS_OPTVAL;
        st_d.val_left = st_q.val_left - 16'd1;
        if (st_q.val_left == 16'd1) opt_done = 1'b1;
      end
      PH_PAYLOAD: begin
        cls = CLS_PAYLOAD;
        if (st_q.pay_cnt != 16'hFFFF) st_d.pay_cnt = st_q.pay_cnt + 16'd1;
      end
      default: begin
        cls = CLS_DISCARD;
      end
    endcase

    // Option header complete: fold the delta into the running number and
    // load the value length. Nibbles below thirteen read as themselves.
    delta_v = nibble_value(st_d.delta_nib, st_d.delta_acc);
    len_v   = nibble_value(st_d.len_nib, st_d.len_acc);
    if (hdr_done) begin
      st_d.run_num  = st_q.run_num + delta_v;
      st_d.cur_len  = len_v;
      st_d.val_left = len_v;
      if (len_v == 16'd0) opt_done = 1'b1;
      else st_d.phase = PH_VALUE;
    end

    if (opt_done) begin
      st_d.seen = seen_inc;
      if (seen_inc >= CNT_W'(MAX_OPTIONS)) begin
        st_d.err   = ST_OPT_LIMIT;
        st_d.phase = PH_DISCARD;
      end else begin
        st_d.phase = PH_OPTHEAD;
      end
    end

    // Final status. A message ending within the first three header bytes is
    // short whatever the version says; after that a recorded error wins.
    if (last) begin
      if (cls == CLS_HEADER && st_q.hdr_idx != 2'd3) status = ST_SHORT;
      else if (st_d.err != ST_OK) status = st_d.err;
      else if (cls == CLS_HEADER || cls == CLS_TOKEN) status = ST_SHORT;
      else if (st_d.phase == PH_EXT || st_d.phase == PH_VALUE) status = ST_TRUNC;
      else status = ST_OK;
    end

    res_d.byte_class     = cls;
    res_d.data_out       = b;
    res_d.option_number  = st_d.run_num;
    res_d.option_length  = st_d.cur_len;
    res_d.message_end    = last;
    res_d.status         = status;
    res_d.msg_type       = st_d.msg_type;
    res_d.token_length   = st_d.tkl;
    res_d.code           = st_d.code;
    res_d.message_id     = st_d.mid;
    res_d.option_count   = st_d.seen[4:0];
    res_d.payload_length = st_d.pay_cnt;
  end

  // --------------------------------------------------------------------------
  // Context and output control. The final byte of a message returns the
  // whole context to its reset value so the next byte opens a new message.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_RESET;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (push) begin
        st_q <= last ? ST_RESET : st_d;
      end
      if (pop) begin
        if (skid_vld_q) begin
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= push;
        end
      end else if (push) begin
        if (!out_vld_q) out_vld_q <= 1'b1;
        else skid_vld_q <= 1'b1;
      end
    end
  end

  // Result payload registers; the valid flags above qualify them.
  always_ff @(posedge clk_i) begin
    if (pop && skid_vld_q) begin
      out_q <= skid_q;
    end else if (push && (pop || !out_vld_q)) begin
      out_q <= res_d;
    end
    if (push && out_vld_q && !pop) begin
      skid_q <= res_d;
    end
  end

`ifndef ASSERT_OFF
  // The skid stage only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid stage holds a result while the output register is empty");

  // Closing a message always brings the parser back to the header phase.
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && last) |=> (st_q.phase == PH_HEADER && st_q.hdr_idx == 2'd0))
    else $error("context not cleared after the final byte of a message");

  // Discarding only follows a recorded error.
  a_discard_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_DISCARD) |-> (st_q.err != ST_OK))
    else $error("discard phase without an error code");

  // A non-zero status appears only on the final byte of a message.
  a_status_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.status == ST_OK || out_q.message_end))
    else $error("status reported before the end of a message");

  // The option counter never passes its limit.
  a_opt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.seen <= CNT_W'(MAX_OPTIONS))
    else $error("option counter beyond its limit");
`endif

endmodule

>>> verif/tb_coap_message_parser_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CoAP message parser testbench
// Drives CoAP messages byte by byte into the parser and checks every result
// against a cycle-free model of the parser kept in this file. A short table
// of hand-picked messages comes first, then random well-formed, broken and
// noisy messages, then a long payload and a quiet tail with no idling.
// ----------------------------------------------------------------------------
module tb_coap_message_parser_top;
  import cmp_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int LIMIT_CYCLES    = 600_000;
  localparam int unsigned MAX_OPTS     = 16;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned LONG_PAYLOAD = 48;

  // Row markers of the directed table: a pinned row carries its own expected
  // byte class and status, a free row is left entirely to the parser model.
  localparam logic PIN  = 1'b1;
  localparam logic FREE = 1'b0;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       pin;
    logic [2:0] cls;
    logic [2:0] st;
  } stim_row_t;

  localparam int N_ROWS = 29;
  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    // A single byte with a bad version: a message ending in the header is
    // reported as too short, whatever the version says.
    '{8'hC0, 1'b1, PIN,  CLS_HEADER,  ST_SHORT},
    // A complete header with version 0, with all-zero and all-one bytes.
    '{8'h00, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'hFF, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'hFF, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h00, 1'b1, PIN,  CLS_HEADER,  ST_BAD_VER},
    // Token length of 15, above the limit of 8.
    '{8'h4F, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h01, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h00, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h00, 1'b1, PIN,  CLS_HEADER,  ST_TKL_LONG},
    // Reserved length nibble: the faulty byte keeps its class, the marker
    // value after it is merely discarded.
    '{8'h40, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h01, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h12, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h34, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h0F, 1'b0, PIN,  CLS_OPTHDR,  ST_OK},
    '{8'hFF, 1'b1, PIN,  CLS_DISCARD, ST_RSVD_NIB},
    // One option with an 8-bit delta extension and a one-byte value, then a
    // payload marker as the final byte: an empty payload is accepted.
    '{8'h60, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'hFF, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'hFF, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'hFF, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'hD1, 1'b0, FREE, CLS_OPTHDR,  ST_OK},
    '{8'hFF, 1'b0, FREE, CLS_OPTHDR,  ST_OK},
    '{8'h00, 1'b0, FREE, CLS_OPTVAL,  ST_OK},
    '{8'hFF, 1'b1, PIN,  CLS_MARKER,  ST_OK},
    // Message cut off between the two bytes of a 16-bit delta extension.
    '{8'h40, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h45, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h00, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'h00, 1'b0, FREE, CLS_HEADER,  ST_OK},
    '{8'hE0, 1'b0, FREE, CLS_OPTHDR,  ST_OK},
    '{8'h12, 1'b1, PIN,  CLS_OPTHDR,  ST_TRUNC}
  };

  // Phases of the parser model.
  typedef enum logic [2:0] {
    PH_HDR, PH_TOK, PH_OPT, PH_EXT, PH_VAL, PH_PAY, PH_DIS
  } parse_phase_e;

  logic clk = 1'b0;
  logic rst_n;

  // Random idling is switched per message, so that some messages run through
  // without any gap; the quiet tail of the run turns it off for good.
  bit idle_on;

  cmp_stream_if #(.payload_t(in_item_t))  req_if ();
  cmp_stream_if #(.payload_t(out_item_t)) res_if ();

  coap_message_parser_top #(
    .MAX_OPTIONS(MAX_OPTS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser model state. It mirrors the block's registers and goes back to its
  // reset values after every byte marked as the last one of a message.
  // --------------------------------------------------------------------------
  parse_phase_e ph;
  logic [15:0]  nbytes;
  logic [1:0]   h_type;
  logic [3:0]   h_tkl;
  logic [7:0]   h_code;
  logic [15:0]  h_mid;
  logic [3:0]   tok_left;
  logic [3:0]   dnib;
  logic [3:0]   lnib;
  logic [2:0]   ext_left;
  logic [15:0]  dacc;
  logic [15:0]  lacc;
  logic [15:0]  opt_num;
  logic [15:0]  cur_len;
  logic [15:0]  val_left;
  logic [6:0]   opts_done;
  logic [15:0]  pay_cnt;
  logic [2:0]   err_code;

  // Results still owed by the block, oldest first.
  out_item_t pending_results[$];
  // Bytes of the message being sent.
  logic [7:0] msg_bytes[$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;

  function automatic void clear_parser();
    ph        = PH_HDR;
    nbytes    = '0;
    h_type    = '0;
    h_tkl     = '0;
    h_code    = '0;
    h_mid     = '0;
    tok_left  = '0;
    dnib      = '0;
    lnib      = '0;
    ext_left  = '0;
    dacc      = '0;
    lacc      = '0;
    opt_num   = '0;
    cur_len   = '0;
    val_left  = '0;
    opts_done = '0;
    pay_cnt   = '0;
    err_code  = ST_OK;
  endfunction

  // Extension bytes that follow a delta or length nibble.
  function automatic logic [1:0] ext_len(input logic [3:0] nib);
    case (nib)
      NIB_EXT8:  return 2'd1;
      NIB_EXT16: return 2'd2;
      default:   return 2'd0;
    endcase
  endfunction

  // Delta or length once the extension bytes are in, modulo 2^16.
  function automatic logic [15:0] nib_value(input logic [3:0] nib, input logic [15:0] acc);
    case (nib)
      NIB_EXT8:  return acc + EXT8_BASE;
      NIB_EXT16: return acc + EXT16_BASE;
      default:   return {12'd0, nib};
    endcase
  endfunction

  function automatic void close_option();
    opts_done = opts_done + 7'd1;
    if (opts_done >= 7'(MAX_OPTS)) begin
      err_code = ST_OPT_LIMIT;
      ph       = PH_DIS;
    end else begin
      ph = PH_OPT;
    end
  endfunction

  function automatic void finish_opt_header();
    logic [15:0] delta;
    delta    = nib_value(dnib, dacc);
    cur_len  = nib_value(lnib, lacc);
    opt_num  = opt_num + delta;
    val_left = cur_len;
    if (val_left == 16'd0) close_option();
    else ph = PH_VAL;
  endfunction

  // Works out the result that one accepted byte gives.
  function automatic out_item_t parse_coap_byte(input logic [7:0] b, input logic lst);
    out_item_t r;
    logic [2:0] cls;
    logic [2:0] st;
    cls = CLS_DISCARD;
    st  = ST_OK;
    case (ph)
      PH_HDR: begin
        cls = CLS_HEADER;
        case (nbytes)
          16'd0: begin
            h_type = b[5:4];
            h_tkl  = b[3:0];
            if (b[7:6] != PROTO_VER) err_code = ST_BAD_VER;
            else if (b[3:0] > MAX_TKL) err_code = ST_TKL_LONG;
          end
          16'd1: h_code = b;
          16'd2: h_mid[15:8] = b;
          default: begin
            h_mid[7:0] = b;
            tok_left   = h_tkl;
            if (err_code != ST_OK) ph = PH_DIS;
            else if (tok_left != 4'd0) ph = PH_TOK;
            else ph = PH_OPT;
          end
        endcase
      end
      PH_TOK: begin
        cls      = CLS_TOKEN;
        tok_left = tok_left - 4'd1;
        if (tok_left == 4'd0) ph = PH_OPT;
      end
      PH_OPT: begin
        if (b == PAYLOAD_MARK) begin
          cls = CLS_MARKER;
          ph  = PH_PAY;
        end else begin
          cls = CLS_OPTHDR;
          if (b[7:4] == NIB_RSVD || b[3:0] == NIB_RSVD) begin
            err_code = ST_RSVD_NIB;
            ph       = PH_DIS;
          end else begin
            dnib     = b[7:4];
            lnib     = b[3:0];
            dacc     = '0;
            lacc     = '0;
            ext_left = 3'(ext_len(dnib)) + 3'(ext_len(lnib));
            if (ext_left == 3'd0) finish_opt_header();
            else ph = PH_EXT;
          end
        end
      end
      PH_EXT: begin
        cls = CLS_OPTHDR;
        if (ext_left > 3'(ext_len(lnib))) dacc = {dacc[7:0], b};
        else lacc = {lacc[7:0], b};
        ext_left = ext_left - 3'd1;
        if (ext_left == 3'd0) finish_opt_header();
      end
      PH_VAL: begin
        cls      = CLS_OPTVAL;
        val_left = val_left - 16'd1;
        if (val_left == 16'd0) close_option();
      end
      PH_PAY: begin
        cls = CLS_PAYLOAD;
        if (pay_cnt != 16'hFFFF) pay_cnt = pay_cnt + 16'd1;
      end
      default: cls = CLS_DISCARD;
    endcase

    if (nbytes != 16'hFFFF) nbytes = nbytes + 16'd1;

    // The status only shows on the final byte. A message that stops inside
    // the header is short even when the header already held an error.
    if (lst) begin
      if (cls == CLS_HEADER && nbytes < 16'd4) st = ST_SHORT;
      else if (err_code != ST_OK) st = err_code;
      else if (cls == CLS_HEADER || cls == CLS_TOKEN) st = ST_SHORT;
      else if (ph == PH_EXT || ph == PH_VAL) st = ST_TRUNC;
    end

    r = '{byte_class: cls, data_out: b, option_number: opt_num, option_length: cur_len,
          message_end: lst, status: st, msg_type: h_type, token_length: h_tkl,
          code: h_code, message_id: h_mid, option_count: opts_done[4:0],
          payload_length: pay_cnt};
    if (lst) clear_parser();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and result checking.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    $display("[%0t] result %0d: %s got %h expected %h", $realtime, results_seen, what,
             got, want);
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.byte_class !== want.byte_class)
      report_mismatch("byte_class", 16'(got.byte_class), 16'(want.byte_class));
    if (got.data_out !== want.data_out)
      report_mismatch("data_out", 16'(got.data_out), 16'(want.data_out));
    if (got.option_number !== want.option_number)
      report_mismatch("option_number", got.option_number, want.option_number);
    if (got.option_length !== want.option_length)
      report_mismatch("option_length", got.option_length, want.option_length);
    if (got.message_end !== want.message_end)
      report_mismatch("message_end", 16'(got.message_end), 16'(want.message_end));
    if (got.status !== want.status)
      report_mismatch("status", 16'(got.status), 16'(want.status));
    if (got.msg_type !== want.msg_type)
      report_mismatch("msg_type", 16'(got.msg_type), 16'(want.msg_type));
    if (got.token_length !== want.token_length)
      report_mismatch("token_length", 16'(got.token_length), 16'(want.token_length));
    if (got.code !== want.code)
      report_mismatch("code", 16'(got.code), 16'(want.code));
    if (got.message_id !== want.message_id)
      report_mismatch("message_id", got.message_id, want.message_id);
    if (got.option_count !== want.option_count)
      report_mismatch("option_count", 16'(got.option_count), 16'(want.option_count));
    if (got.payload_length !== want.payload_length)
      report_mismatch("payload_length", got.payload_length, want.payload_length);
  endtask

  // Every result request taken by the testbench is matched against the
  // oldest outstanding expectation. Sampling at the rising edge sees the
  // values from before the edge, so no ordering within the step matters.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected", 16'(res_if.data.data_out), 16'd0);
      end else begin
        want = pending_results.pop_front();
        check_result(res_if.data, want);
      end
      results_seen++;
    end
  end

  // Result side: ready drops in random bursts while idling is on.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) stall_left--;
      else if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 4);
      res_if.ready <= (stall_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  // Offers one byte, waits for the request to be taken and records the
  // expected result. A pinned byte takes its class and status from the table.
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic pinned,
                           input logic [2:0] cls, input logic [2:0] st);
    out_item_t want;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= '{data_byte: b, last_byte: lst};
    do @(posedge clk); while (!req_if.ready);
    want = parse_coap_byte(b, lst);
    if (pinned) begin
      want.byte_class = cls;
      want.status     = st;
    end
    pending_results.push_back(want);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1, FREE, CLS_HEADER, ST_OK);
  endtask

  // Stops offering requests until every outstanding result has come back.
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Builds a well-formed message with random content: a version 1 header,
  // a token of 0 to 8 bytes, options with every nibble form and sometimes a
  // payload. Some messages carry enough short options to hit the option
  // limit; long option values and random cuts end messages early, which
  // gives the short and truncated cases.
  task automatic build_wellformed();
    int unsigned tkl;
    int unsigned nopt;
    int unsigned lenval;
    int unsigned cut;
    logic [3:0]  dn;
    logic [3:0]  ln;
    logic [7:0]  eb;
    logic [15:0] w;
    logic [15:0] wl;
    bit          short_opts;
    bit          stop;
    msg_bytes.delete();
    tkl = $urandom_range(0, 8);
    msg_bytes.push_back({PROTO_VER, 2'($urandom_range(0, 3)), 4'(tkl)});
    repeat (3) msg_bytes.push_back(8'($urandom));
    repeat (tkl) msg_bytes.push_back(8'($urandom));
    short_opts = ($urandom_range(0, 4) == 0);
    nopt = short_opts ? $urandom_range(14, 18) : $urandom_range(0, 4);
    stop = 1'b0;
    for (int k = 0; k < nopt && !stop; k++) begin
      dn = 4'($urandom_range(0, 14));
      ln = short_opts ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 14));
      msg_bytes.push_back({dn, ln});
      if (dn == NIB_EXT8) begin
        msg_bytes.push_back(8'($urandom));
      end else if (dn == NIB_EXT16) begin
        msg_bytes.push_back(8'($urandom));
        msg_bytes.push_back(8'($urandom));
      end
      lenval = 32'(ln);
      if (ln == NIB_EXT8) begin
        eb = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        msg_bytes.push_back(eb);
        lenval = 32'(eb) + 32'd13;
      end else if (ln == NIB_EXT16) begin
        w  = 16'($urandom);
        wl = w + EXT16_BASE;
        msg_bytes.push_back(w[15:8]);
        msg_bytes.push_back(w[7:0]);
        lenval = 32'(wl);
      end
      // Long values are cut short, so the message ends inside the value.
      if (lenval > 32) begin
        lenval = $urandom_range(0, 32);
        stop   = 1'b1;
      end
      repeat (lenval) msg_bytes.push_back(8'($urandom));
    end
    if (!stop && $urandom_range(0, 1) == 1) begin
      msg_bytes.push_back(PAYLOAD_MARK);
      repeat ($urandom_range(0, 8)) msg_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned since_drain;
    int unsigned kind;
    int unsigned n;
    clear_parser();
    idle_on      = 1'b0;
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with idling on both sides.
    idle_on = 1'b1;
    for (int i = 0; i < N_ROWS; i++)
      send_byte(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].pin, DIR_ROWS[i].cls,
                DIR_ROWS[i].st);
    hold_until_drained();

    // Random part: mostly well-formed messages, some with one byte
    // overwritten, and some plain noise. Noise often starts with a valid
    // version so that random bytes reach the token and option phases too.
    sent        = 0;
    since_drain = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 9);
      if (kind < 8) begin
        build_wellformed();
        if (kind == 7) msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
      end else begin
        msg_bytes.delete();
        n = $urandom_range(1, 10);
        msg_bytes.push_back(kind == 8 ? {PROTO_VER, 6'($urandom)} : 8'($urandom));
        repeat (n - 1) msg_bytes.push_back(8'($urandom));
      end
      send_message();
      sent        += msg_bytes.size();
      since_drain += msg_bytes.size();
      if (since_drain > 150) begin
        hold_until_drained();
        since_drain = 0;
      end
    end

    // Quiet tail: no idling on either side. A message with a payload of a
    // few dozen bytes, then a few more random messages.
    idle_on = 1'b0;
    msg_bytes.delete();
    msg_bytes.push_back({PROTO_VER, 2'd0, 4'd0});
    repeat (3) msg_bytes.push_back(8'($urandom));
    msg_bytes.push_back(PAYLOAD_MARK);
    repeat (LONG_PAYLOAD) msg_bytes.push_back(8'($urandom));
    send_message();
    repeat (5) begin
      build_wellformed();
      send_message();
    end

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Hard limit on the run, well above the slowest correct run.
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

endmodule
